@@ hdl/cmdlex_pkg.sv @@
// package for the command token lexer
// holds token kinds, token categories, result record and saturating digit step
// no dependencies
`timescale 1ns / 1ps

package cmdlex_pkg;

  // longest token buffer; a token is cut at BUFFER_LEN-1 characters
  localparam int unsigned BUFFER_LEN = 255;
  localparam int unsigned LEN_W      = $clog2(BUFFER_LEN);

  // token kinds on the result channel
  localparam logic [3:0] KIND_DELIM = 4'd0;
  localparam logic [3:0] KIND_EXIT  = 4'd7;
  localparam logic [3:0] KIND_RUN   = 4'd8;
  localparam logic [3:0] KIND_SKIP  = 4'd9;

  // category of the token in progress; codes 1..6 equal the token kinds
  typedef enum logic [2:0] {
    CAT_NONE  = 3'd0,
    CAT_INT   = 3'd1,
    CAT_PCT   = 3'd2,
    CAT_FRAME = 3'd3,
    CAT_FRAC  = 3'd4,
    CAT_CHAR  = 3'd5,
    CAT_WORD  = 3'd6
  } cat_e;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_POINT = 8'h2E;

  // keywords, first character in the top byte
  localparam logic [31:0] KW_EXIT = "exit";
  localparam logic [23:0] KW_RUN  = "run";
  localparam logic [31:0] KW_SKIP = "skip";

  // one result transaction
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [7:0]  frac;
    logic        trunc;
    logic        last;
  } res_t;

  // acc * base + d, saturating at all ones; base is 10 when dec is set, else 8
  function automatic logic [31:0] mac_sat(input logic [31:0] acc, input logic [3:0] d,
                                          input logic dec);
    logic [35:0] p;
    p = {4'd0, acc} << 3;
    if (dec) begin
      p = p + ({4'd0, acc} << 1);
    end
    p = p + {32'd0, d};
    return (p[35:32] != 4'd0) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

endpackage

@@ hdl/command_token_lexer_top.sv @@
// command token lexer: cuts a character stream into classified tokens
// input register, single-pass token logic, four-entry result queue
// depends on cmdlex_pkg
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  symbol  | in_valid_i, in_ready_o, symbol_i                 | in
//  token   | out_valid_o, out_ready_i, token_kind_o, value_o, | out
//          | frac_digits_o, truncated_o, last_o               |
//
// one character per cycle while the input register can drain; a character is taken into
// the input register, then handled and its results written into the result queue
// the input register drains only while the result queue has two free slots,
// so a stalled consumer stops intake after at most four queued results
// rst_ni clears token state and the queue; the keyword buffer needs no reset
`timescale 1ns / 1ps

module command_token_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [31:0] value_o,
  output logic [7:0]  frac_digits_o,
  output logic        truncated_o,
  output logic        last_o
);
  import cmdlex_pkg::*;

  // input register
  logic              stg_valid_q;
  logic [7:0]        stg_sym_q;

  // token state
  cat_e              cat_q, cat_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       man_q, man_d;
  logic              oct_q, oct_d;
  logic              ostop_q, ostop_d;
  logic [7:0]        fcnt_q, fcnt_d;
  logic [7:0]        lead_q [4];
  logic              lead_we;

  // result queue
  res_t              fifo_q [4];
  logic [1:0]        wr_ptr_q, rd_ptr_q;
  logic [2:0]        cnt_q;

  // step logic
  logic              fire, pop;
  logic [7:0]        c;
  logic              is_blank, is_delim, is_digit, is_alpha;
  logic [3:0]        dig;
  logic [LEN_W:0]    len_inc;
  res_t              res0, res1;
  logic [1:0]        n_push;

  assign fire       = stg_valid_q && (cnt_q <= 3'd2);
  assign in_ready_o = !stg_valid_q || fire;
  assign pop        = out_valid_o && out_ready_i;

  // character classes after case folding
  always_comb begin
    c = stg_sym_q;
    if (stg_sym_q >= CH_UA && stg_sym_q <= CH_UZ) begin
      c = stg_sym_q + 8'd32;
    end
    is_blank = (c == CH_SPACE) || (c == CH_TAB);
    is_delim = (c == CH_SEMI) || (c == CH_CR) || (c == CH_LF);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_alpha = (c >= CH_LA) && (c <= CH_LZ);
    dig      = c[3:0];
  end

  // token step: next state and up to two results
  always_comb begin
    cat_d   = cat_q;
    len_d   = len_q;
    acc_d   = acc_q;
    man_d   = man_q;
    oct_d   = oct_q;
    ostop_d = ostop_q;
    fcnt_d  = fcnt_q;
    lead_we = 1'b0;
    res0    = '0;
    res1    = '0;
    n_push  = 2'd0;
    len_inc = {1'b0, len_q} + {{LEN_W{1'b0}}, 1'b1};

    if (is_blank || is_delim) begin
      if (cat_q != CAT_NONE) begin
        res0.kind = 4'(cat_q);
        unique case (cat_q) inside
          CAT_INT, CAT_PCT, CAT_FRAME: res0.value = acc_q;
          CAT_FRAC: begin
            res0.value = man_q;
            res0.frac  = fcnt_q;
          end
          CAT_WORD: begin
            if (len_q == LEN_W'(4) && {lead_q[0], lead_q[1], lead_q[2], lead_q[3]} == KW_EXIT) begin
              res0.kind = KIND_EXIT;
            end else if (len_q == LEN_W'(3) && {lead_q[0], lead_q[1], lead_q[2]} == KW_RUN) begin
              res0.kind = KIND_RUN;
            end else if (len_q == LEN_W'(4) &&
                         {lead_q[0], lead_q[1], lead_q[2], lead_q[3]} == KW_SKIP) begin
              res0.kind = KIND_SKIP;
            end
          end
          default: ;
        endcase
        res0.last = !is_delim;
        res1.kind = KIND_DELIM;
        res1.last = 1'b1;
        n_push    = is_delim ? 2'd2 : 2'd1;
        cat_d     = CAT_NONE;
        len_d     = '0;
        acc_d     = '0;
        man_d     = '0;
        oct_d     = 1'b0;
        ostop_d   = 1'b0;
        fcnt_d    = '0;
      end
    end else begin
      lead_we = (len_q < LEN_W'(4));

      // category transition
      unique case (cat_q)
        CAT_NONE: begin
          if (is_digit) begin
            cat_d = CAT_INT;
            oct_d = (c == CH_ZERO);
          end else if (c == CH_POINT) begin
            cat_d = CAT_FRAC;
          end else if (is_alpha) begin
            cat_d = CAT_WORD;
          end else begin
            cat_d = CAT_CHAR;
          end
        end
        CAT_INT: begin
          if (!is_digit) begin
            if (c == CH_F) begin
              cat_d = CAT_FRAME;
            end else if (c == CH_PCT) begin
              cat_d = CAT_PCT;
            end else if (c == CH_POINT) begin
              cat_d = CAT_FRAC;
            end else begin
              cat_d = CAT_WORD;
            end
          end
        end
        CAT_FRAC: begin
          if (!is_digit) begin
            cat_d = CAT_WORD;
          end
        end
        default: cat_d = CAT_WORD;
      endcase

      // digit accumulation
      if (is_digit && (cat_d == CAT_INT || cat_d == CAT_FRAC)) begin
        if (cat_d == CAT_INT) begin
          if (oct_d) begin
            if (!ostop_q) begin
              if (dig >= 4'd8) begin
                ostop_d = 1'b1;
              end else begin
                acc_d = mac_sat(acc_q, dig, 1'b0);
              end
            end
          end else begin
            acc_d = mac_sat(acc_q, dig, 1'b1);
          end
        end
        man_d = mac_sat(man_q, dig, 1'b1);
        if (cat_q == CAT_FRAC && fcnt_q != 8'hFF) begin
          fcnt_d = fcnt_q + 8'd1;
        end
      end

      len_d = len_inc[LEN_W-1:0];

      // buffer limit reached
      if (len_inc >= (LEN_W+1)'(BUFFER_LEN - 1)) begin
        res0.kind  = 4'(cat_d);
        res0.trunc = 1'b1;
        res0.last  = 1'b1;
        n_push     = 2'd1;
        cat_d      = CAT_NONE;
        len_d      = '0;
        acc_d      = '0;
        man_d      = '0;
        oct_d      = 1'b0;
        ostop_d    = 1'b0;
        fcnt_d     = '0;
      end
    end
  end

  // input register and token state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      cat_q       <= CAT_NONE;
      len_q       <= '0;
      acc_q       <= '0;
      man_q       <= '0;
      oct_q       <= 1'b0;
      ostop_q     <= 1'b0;
      fcnt_q      <= '0;
    end else begin
      if (in_ready_o) begin
        stg_valid_q <= in_valid_i;
      end
      if (fire) begin
        cat_q   <= cat_d;
        len_q   <= len_d;
        acc_q   <= acc_d;
        man_q   <= man_d;
        oct_q   <= oct_d;
        ostop_q <= ostop_d;
        fcnt_q  <= fcnt_d;
      end
    end
  end

  // payload registers: captured symbol and leading characters
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_sym_q <= symbol_i;
    end
    if (fire && lead_we) begin
      lead_q[len_q[1:0]] <= c;
    end
  end

  // result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + n_push;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (fire ? {1'b0, n_push} : 3'd0) - {2'b0, pop};
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (fire && n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (fire && n_push == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  // result channel
  assign out_valid_o   = (cnt_q != 3'd0);
  assign token_kind_o  = fifo_q[rd_ptr_q].kind;
  assign value_o       = fifo_q[rd_ptr_q].value;
  assign frac_digits_o = fifo_q[rd_ptr_q].frac;
  assign truncated_o   = fifo_q[rd_ptr_q].trunc;
  assign last_o        = fifo_q[rd_ptr_q].last;

endmodule
